@@ rtl/core/mbf_pkg.sv @@
// ----------------------------------------------------------------------------
// mbf_pkg
// Shared types and constants of the metaball voxel field evaluator.
// ----------------------------------------------------------------------------
package mbf_pkg;
    localparam int MAX_BALLS = 8;
    localparam int GRID_SIZE = 8;
    localparam int BALL_W    = $clog2(MAX_BALLS);
    localparam int CNT_W     = $clog2(MAX_BALLS + 1);

    // distance squared: 3 * (2^16)^2 < 2^34
    localparam int SQ_W   = 34;
    localparam int DIST_W = 17;
    localparam int DEN_W  = 18;
    localparam int NUM_W  = 40;
    localparam int SUM_W  = 44;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;
    localparam logic [1:0] REQ_VOXEL   = 2'd2;
    localparam logic [1:0] REQ_RSVD    = 2'd3;

    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    localparam logic [DEN_W-1:0] DEN_BIAS = DEN_W'(3072);
    localparam logic signed [17:0] TOP_POS = 18'(GRID_SIZE * 4096);

    typedef enum logic [2:0] {
        S_IDLE, S_ADV, S_DIST, S_SQRT, S_DIV, S_OUT
    } t_state;

    // start and done between sequencer and the iterative divide/sqrt unit
    typedef struct packed {
        logic start;
        logic is_sqrt;
    } t_unit_ctl;

    typedef struct packed {
        logic done;
    } t_unit_sts;
endpackage

@@ rtl/core/metaball_field_voxel_eval.sv @@
// ----------------------------------------------------------------------------
// metaball_field_voxel_eval
// Metaball field evaluator: keeps ball state, advances balls, sums the field.
// ----------------------------------------------------------------------------
// Load is taken in the idle state. Advance steps each active ball axis by
// axis. Voxel: per active ball, a distance step for each axis, then a square
// root and a divide in the shared bit-serial unit. No new item is accepted
// until the result is loaded, which waits while the last one is not taken.
// Synchronous active-low reset clears all ball state and restores the
// default radius and count registers.
module metaball_field_voxel_eval
    import mbf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_req_type,
    input  logic [2:0]         i_ball_index,
    input  logic signed [15:0] i_load_pos_x,
    input  logic signed [15:0] i_load_pos_y,
    input  logic signed [15:0] i_load_pos_z,
    input  logic signed [15:0] i_load_speed_x,
    input  logic signed [15:0] i_load_speed_y,
    input  logic signed [15:0] i_load_speed_z,
    input  logic [2:0]         i_voxel_x,
    input  logic [2:0]         i_voxel_y,
    input  logic [2:0]         i_voxel_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_hue,
    output logic [15:0]        o_field_sum
);
    logic signed [15:0] r_pos [MAX_BALLS][3];
    logic signed [15:0] r_spd [MAX_BALLS][3];
    logic [15:0]        r_radius;
    logic [3:0]         r_count;
    t_state             r_state, n_state;
    logic [BALL_W-1:0]  r_ball;
    logic [1:0]         r_axis;
    logic [SQ_W-1:0]    r_sq;
    logic [SUM_W-1:0]   r_sum;
    logic [2:0]         r_vox [3];
    logic               r_ovalid;
    logic [7:0]         r_hue;
    logic [15:0]        r_fsum;
    logic               r_wait;

    t_unit_ctl          w_ctl;
    t_unit_sts          w_sts;
    logic [NUM_W-1:0]   w_num, w_res;
    logic [DEN_W-1:0]   w_den;
    logic [CNT_W-1:0]   w_n;
    logic               w_last;
    logic               w_acc;
    logic               w_out_load;
    logic signed [16:0] w_d;
    logic signed [33:0] w_dsq;
    logic signed [17:0] w_p1, w_p2;
    logic signed [16:0] w_nspd;
    logic signed [15:0] w_nspd_s;

    assign w_n    = (r_count > 4'(MAX_BALLS)) ? CNT_W'(MAX_BALLS) : CNT_W'(r_count);
    assign w_last = ({1'b0, r_ball} == CNT_W'(w_n - CNT_W'(1)));
    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;
    // load the output register once the previous result has left or is being taken
    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || i_ready);

    // signed distance on the current axis
    assign w_d = 17'(r_pos[r_ball][r_axis]) - 17'($signed({1'b0, r_vox[r_axis], 12'd0}));
    assign w_dsq = w_d * w_d;

    // advance arithmetic on the current axis
    assign w_p1   = 18'(r_pos[r_ball][r_axis]) + 18'(r_spd[r_ball][r_axis]);
    assign w_nspd = -17'(r_spd[r_ball][r_axis]);
    assign w_nspd_s = (w_nspd > 17'sd32767) ? 16'sh7fff : w_nspd[15:0];
    assign w_p2   = w_p1 + 18'(w_nspd_s);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_req_type == REQ_ADVANCE && w_n != '0) n_state = S_ADV;
                    else if (i_req_type == REQ_VOXEL) n_state = (w_n != '0) ? S_DIST : S_OUT;
                end
            end
            S_ADV:  if (r_axis == 2'd2 && w_last) n_state = S_IDLE;
            S_DIST: if (r_axis == 2'd2) n_state = S_SQRT;
            S_SQRT: if (w_sts.done) n_state = S_DIV;
            S_DIV:  if (w_sts.done) n_state = w_last ? S_OUT : S_DIST;
            S_OUT:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ctl = '0;
        w_num = '0;
        w_den = '0;
        unique case (r_state)
            S_SQRT: begin
                w_ctl.start   = !r_wait;
                w_ctl.is_sqrt = 1'b1;
                w_num = NUM_W'(r_sq);
            end
            S_DIV: begin
                w_ctl.start = !r_wait;
                w_num = {r_radius, 24'd0};
                w_den = DEN_BIAS + DEN_W'(w_res[DIST_W-1:0]);
            end
            default: ;
        endcase
    end

    mbf_iter_unit u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_sts  (w_sts),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_radius <= 16'd4800;
            r_count  <= 4'd8;
            r_ovalid <= 1'b0;
            r_ball   <= '0;
            r_axis   <= '0;
            r_wait   <= 1'b0;
            for (int b = 0; b < MAX_BALLS; b++) begin
                for (int a = 0; a < 3; a++) begin
                    r_pos[b][a] <= '0;
                    r_spd[b][a] <= '0;
                end
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RADIUS) r_radius <= i_cfg_data;
                else r_count <= i_cfg_data[3:0];
            end
            if (w_out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            r_wait <= w_ctl.start ? 1'b1 : (w_sts.done ? 1'b0 : r_wait);
            unique case (r_state)
                S_IDLE: begin
                    r_ball <= '0;
                    r_axis <= '0;
                    r_sq   <= '0;
                    r_sum  <= '0;
                    r_vox[0] <= i_voxel_x;
                    r_vox[1] <= i_voxel_y;
                    r_vox[2] <= i_voxel_z;
                    if (w_acc && i_req_type == REQ_LOAD &&
                        32'(i_ball_index) < MAX_BALLS) begin
                        r_pos[BALL_W'(i_ball_index)][0] <= i_load_pos_x;
                        r_pos[BALL_W'(i_ball_index)][1] <= i_load_pos_y;
                        r_pos[BALL_W'(i_ball_index)][2] <= i_load_pos_z;
                        r_spd[BALL_W'(i_ball_index)][0] <= i_load_speed_x;
                        r_spd[BALL_W'(i_ball_index)][1] <= i_load_speed_y;
                        r_spd[BALL_W'(i_ball_index)][2] <= i_load_speed_z;
                    end
                end
                S_ADV: begin
                    if (w_p1 < 0 || w_p1 > TOP_POS) begin
                        r_spd[r_ball][r_axis] <= w_nspd_s;
                        r_pos[r_ball][r_axis] <= (w_p2 > 18'sd32767) ? 16'sh7fff :
                            (w_p2 < -18'sd32768) ? 16'sh8000 : w_p2[15:0];
                    end else begin
                        r_pos[r_ball][r_axis] <= (w_p1 > 18'sd32767) ? 16'sh7fff :
                            (w_p1 < -18'sd32768) ? 16'sh8000 : w_p1[15:0];
                    end
                    if (r_axis == 2'd2) begin
                        r_axis <= '0;
                        r_ball <= r_ball + BALL_W'(1);
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                S_DIST: begin
                    r_sq <= r_sq + SQ_W'(unsigned'(w_dsq));
                    r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                end
                S_DIV: begin
                    if (w_sts.done) begin
                        r_sum  <= r_sum + SUM_W'(w_res);
                        r_sq   <= '0;
                        r_ball <= r_ball + BALL_W'(1);
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_hue  <= r_sum[23:16];
                        r_fsum <= (r_sum[SUM_W-1:32] != '0) ? 16'hffff : r_sum[31:16];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_hue       = r_hue;
    assign o_field_sum = r_fsum;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid && $stable(r_fsum))
        else $error("result dropped while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.start |=> !w_ctl.start)
        else $error("unit restarted");
endmodule

@@ rtl/core/mbf_iter_unit.sv @@
// ----------------------------------------------------------------------------
// mbf_iter_unit
// Shared bit-serial unit: integer square root of SQ_W bits or restoring
// division of NUM_W by DEN_W bits, one result bit per cycle while busy.
// ----------------------------------------------------------------------------
module mbf_iter_unit
    import mbf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_unit_ctl         i_ctl,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output t_unit_sts         o_sts,
    output logic [NUM_W-1:0]  o_res
);
    localparam int RW = DEN_W + 2;
    localparam int IW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q, n_q;
    logic [RW-1:0]    r_rem, n_rem;
    logic [NUM_W-1:0] r_src, n_src;
    logic [DEN_W-1:0] r_den;
    logic [IW-1:0]    r_cnt, n_cnt;
    logic             r_sqrt, r_busy, r_done;
    logic [RW-1:0]    w_trial, w_sub;

    always_comb begin
        n_src = r_src;
        n_q   = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        if (r_sqrt) begin
            // bring down two bits, trial 4*root+1
            w_trial = {r_rem[RW-3:0], r_src[NUM_W-1 -: 2]};
            w_sub   = {r_q[RW-3:0], 2'b01};
            n_src   = {r_src[NUM_W-3:0], 2'b00};
        end else begin
            w_trial = {r_rem[RW-2:0], r_src[NUM_W-1]};
            w_sub   = RW'(r_den);
            n_src   = {r_src[NUM_W-2:0], 1'b0};
        end
        if (w_trial >= w_sub) begin
            n_rem = w_trial - w_sub;
            n_q   = {r_q[NUM_W-2:0], 1'b1};
        end else begin
            n_rem = w_trial;
            n_q   = {r_q[NUM_W-2:0], 1'b0};
        end
        n_cnt = r_cnt - IW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt == IW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_sqrt <= i_ctl.is_sqrt;
            r_den  <= i_den;
            r_rem  <= '0;
            r_q    <= '0;
            if (i_ctl.is_sqrt) begin
                r_src <= {i_num[SQ_W-1:0], {(NUM_W-SQ_W){1'b0}}};
                r_cnt <= IW'(SQ_W / 2);
            end else begin
                r_src <= i_num;
                r_cnt <= IW'(NUM_W);
            end
        end else if (r_busy) begin
            r_src <= n_src;
            r_q   <= n_q;
            r_rem <= n_rem;
            r_cnt <= n_cnt;
        end
    end

    assign o_sts.done = r_done;
    assign o_res      = r_q;
endmodule
